[hw/rtl/ftc_pkg.sv]
// Shared types, widths and calibration constants of the force/torque converter.
`timescale 1ns / 1ps

package ftc_pkg;

  // Channel and arithmetic widths.
  localparam int NUM_GAUGES = 6;
  localparam int NUM_AXES   = 6;
  localparam int GAUGE_W    = 18;
  localparam int DIFF_W     = GAUGE_W + 1;
  localparam int COEF_W     = 26;
  localparam int PROD_W     = DIFF_W + COEF_W;
  localparam int PAIR_W     = PROD_W + 1;
  localparam int ACC_W      = 50;
  localparam int FRAC_DROP  = 16;
  localparam int SH_W       = ACC_W - FRAC_DROP;
  localparam int OUT_W      = 32;
  localparam int QUO_W      = GAUGE_W;

  localparam int BIAS_SAMPLES_DEF = 16;

  // Command codes carried by in_cmd.
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_BIAS    = 1'b1;

  // Rounding and saturation of the Q.32 sums to Q15.16.
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd32768);
  localparam logic signed [SH_W-1:0]  SH_MAX     = SH_W'(64'sd2147483647);
  localparam logic signed [SH_W-1:0]  SH_MIN     = SH_W'(-64'sd2147483648);

  // Row scales: force rows by -20.4, torque rows by -1.23, both in Q.20.
  localparam longint FORCE_NUM  = -64'sd204 * 64'sd1048576;
  localparam longint FORCE_DEN  = 64'sd10000000;
  localparam longint TORQUE_NUM = -64'sd123 * 64'sd1048576;
  localparam longint TORQUE_DEN = 64'sd100000000;

  // Bias divider sequencer states.
  typedef enum logic [1:0] {
    BIAS_IDLE,
    BIAS_LOAD,
    BIAS_STORE
  } bias_state_t;

  // Controls of the bias dividers.
  typedef struct packed {
    logic load;
  } div_ctl_t;

  // Stage loads of the matrix lanes.
  typedef struct packed {
    logic ld_prod;
    logic ld_pair;
    logic ld_sum;
  } lane_ctl_t;

  // Force coefficient from a matrix entry in millionths, rounded half away from zero.
  function automatic logic signed [COEF_W-1:0] coef_force(input longint m);
    longint p;
    longint q;
    p = m * FORCE_NUM;
    if (p >= 0) begin
      q = (p + FORCE_DEN / 2) / FORCE_DEN;
    end else begin
      q = -((-p + FORCE_DEN / 2) / FORCE_DEN);
    end
    return COEF_W'(q);
  endfunction

  // Torque coefficient from a matrix entry in millionths, rounded half away from zero.
  function automatic logic signed [COEF_W-1:0] coef_torque(input longint m);
    longint p;
    longint q;
    p = m * TORQUE_NUM;
    if (p >= 0) begin
      q = (p + TORQUE_DEN / 2) / TORQUE_DEN;
    end else begin
      q = -((-p + TORQUE_DEN / 2) / TORQUE_DEN);
    end
    return COEF_W'(q);
  endfunction

  // Calibration matrix with the row scales folded in, one row per axis.
  localparam logic signed [COEF_W-1:0] COEF [NUM_AXES][NUM_GAUGES] = '{
    '{coef_force(-22), coef_force(1325), coef_force(-35134),
      coef_force(640126), coef_force(51951), coef_force(-641909)},
    '{coef_force(17570), coef_force(-743414), coef_force(-16234),
      coef_force(372558), coef_force(-32329), coef_force(366082)},
    '{coef_force(-1184654), coef_force(-12028), coef_force(-1165485),
      coef_force(-14266), coef_force(-1174821), coef_force(2540)},
    '{coef_torque(7847), coef_torque(-144965), coef_torque(552931),
      coef_torque(79813), coef_torque(-571950), coef_torque(71877)},
    '{coef_torque(-661215), coef_torque(-7048), coef_torque(337836),
      coef_torque(-125610), coef_torque(315335), coef_torque(132327)},
    '{coef_torque(-10556), coef_torque(346443), coef_torque(-9666),
      coef_torque(344562), coef_torque(-31572), coef_torque(339944)}
  };

endpackage

[hw/rtl/six_axis_force_torque_converter.sv]
// Top level of the six-axis force/torque converter.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall  | cmd, gauge_0..gauge_5 (Q5.12)
//   out_    | output    | out_valid/out_stall| force_x..torque_z (Q15.16), bias_ready
//
// A measure beat runs through five register stages (difference, products,
// pair sums, row sum, output) and the block takes one beat per cycle unless
// a stalled output backs up to the input or the bias dividers are at work.
// The beat that completes a bias run starts the six bias dividers; the input
// stalls while the reciprocal products are registered and the new levels stored.
// Reset is synchronous and active low; the bias is zero until a run finishes.
// Each stage advances whenever the stage after it is free or moving, so
// bubbles close up while the output beat is stalled.
`timescale 1ns / 1ps

module six_axis_force_torque_converter #(
  parameter int BIAS_SAMPLES = ftc_pkg::BIAS_SAMPLES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_cmd,
  input  logic signed [ftc_pkg::GAUGE_W-1:0]    in_gauge_0,
  input  logic signed [ftc_pkg::GAUGE_W-1:0]    in_gauge_1,
  input  logic signed [ftc_pkg::GAUGE_W-1:0]    in_gauge_2,
  input  logic signed [ftc_pkg::GAUGE_W-1:0]    in_gauge_3,
  input  logic signed [ftc_pkg::GAUGE_W-1:0]    in_gauge_4,
  input  logic signed [ftc_pkg::GAUGE_W-1:0]    in_gauge_5,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ftc_pkg::OUT_W-1:0]      out_force_x,
  output logic signed [ftc_pkg::OUT_W-1:0]      out_force_y,
  output logic signed [ftc_pkg::OUT_W-1:0]      out_force_z,
  output logic signed [ftc_pkg::OUT_W-1:0]      out_torque_x,
  output logic signed [ftc_pkg::OUT_W-1:0]      out_torque_y,
  output logic signed [ftc_pkg::OUT_W-1:0]      out_torque_z,
  output logic                                  out_bias_ready
);

  localparam int SUM_W = ftc_pkg::GAUGE_W + $clog2(BIAS_SAMPLES);
  localparam int CNT_W = $clog2(BIAS_SAMPLES + 1);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(BIAS_SAMPLES - 1);

  logic signed [ftc_pkg::GAUGE_W-1:0] gauge [ftc_pkg::NUM_GAUGES];

  // Bias state.
  logic signed [SUM_W-1:0]            bias_sum_r   [ftc_pkg::NUM_GAUGES];
  logic signed [ftc_pkg::GAUGE_W-1:0] bias_level_r [ftc_pkg::NUM_GAUGES];
  logic signed [ftc_pkg::GAUGE_W-1:0] div_level    [ftc_pkg::NUM_GAUGES];
  logic [CNT_W-1:0]                   bias_count_r;
  logic                               bias_done_r;

  // Divider sequencer.
  ftc_pkg::bias_state_t               state_r, state_nxt;
  ftc_pkg::div_ctl_t                  div_ctl;
  logic                               store;

  // Measure pipeline.
  logic                               in_acc, bias_acc, meas_acc, run_end;
  logic                               ld0, ld1, ld2, ld3, ld_out;
  logic                               v0_r, v1_r, v2_r, v3_r;
  logic                               rdy0_r, rdy1_r, rdy2_r, rdy3_r;
  logic signed [ftc_pkg::DIFF_W-1:0]  diff_r [ftc_pkg::NUM_GAUGES];
  ftc_pkg::lane_ctl_t                 lane_ctl;
  logic signed [ftc_pkg::ACC_W-1:0]   lane_acc [ftc_pkg::NUM_AXES];
  logic signed [ftc_pkg::OUT_W-1:0]   axis [ftc_pkg::NUM_AXES];

  assign gauge[0] = in_gauge_0;
  assign gauge[1] = in_gauge_1;
  assign gauge[2] = in_gauge_2;
  assign gauge[3] = in_gauge_3;
  assign gauge[4] = in_gauge_4;
  assign gauge[5] = in_gauge_5;

  // Stage loads: a stage takes new data when it is empty or its data moves on.
  assign ld_out = !out_valid || !out_stall;
  assign ld3    = !v3_r || ld_out;
  assign ld2    = !v2_r || ld3;
  assign ld1    = !v1_r || ld2;
  assign ld0    = !v0_r || ld1;

  assign in_stall = (state_r != ftc_pkg::BIAS_IDLE) || !ld0;
  assign in_acc   = in_valid && !in_stall;
  assign bias_acc = in_acc && (in_cmd == ftc_pkg::CMD_BIAS);
  assign meas_acc = in_acc && (in_cmd == ftc_pkg::CMD_MEASURE);
  assign run_end  = bias_acc && (bias_count_r == CNT_LAST);

  // Running sums; the first beat of a run replaces the old sums.
  always_ff @(posedge clk) begin
    if (bias_acc) begin
      for (int c = 0; c < ftc_pkg::NUM_GAUGES; c++) begin
        if (bias_count_r == '0) begin
          bias_sum_r[c] <= SUM_W'(gauge[c]);
        end else begin
          bias_sum_r[c] <= bias_sum_r[c] + SUM_W'(gauge[c]);
        end
      end
    end
  end

  // Run count and completion flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_count_r <= '0;
      bias_done_r  <= 1'b0;
    end else begin
      if (run_end) begin
        bias_count_r <= '0;
      end else if (bias_acc) begin
        bias_count_r <= bias_count_r + 1'b1;
      end
      if (store) begin
        bias_done_r <= 1'b1;
      end
    end
  end

  // Bias levels, written once the dividers are through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < ftc_pkg::NUM_GAUGES; c++) begin
        bias_level_r[c] <= '0;
      end
    end else if (store) begin
      bias_level_r <= div_level;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ftc_pkg::BIAS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state and controls.
  always_comb begin
    state_nxt    = state_r;
    div_ctl      = '0;
    store        = 1'b0;
    case (state_r)
      ftc_pkg::BIAS_IDLE: begin
        if (run_end) begin
          state_nxt = ftc_pkg::BIAS_LOAD;
        end
      end
      ftc_pkg::BIAS_LOAD: begin
        div_ctl.load = 1'b1;
        state_nxt    = ftc_pkg::BIAS_STORE;
      end
      ftc_pkg::BIAS_STORE: begin
        store     = 1'b1;
        state_nxt = ftc_pkg::BIAS_IDLE;
      end
      default: begin
        state_nxt = ftc_pkg::BIAS_IDLE;
      end
    endcase
  end

  // One divider per gauge.
  for (genvar c = 0; c < ftc_pkg::NUM_GAUGES; c++) begin : g_div
    ftc_div #(
      .BIAS_SAMPLES (BIAS_SAMPLES)
    ) u_div (
      .clk   (clk),
      .ctl   (div_ctl),
      .sum   (bias_sum_r[c]),
      .level (div_level[c])
    );
  end

  // Pipeline valid flags and the bias-ready tag that rides along.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld0) v0_r <= meas_acc;
      if (ld1) v1_r <= v0_r;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0) rdy0_r <= bias_done_r;
    if (ld1) rdy1_r <= rdy0_r;
    if (ld2) rdy2_r <= rdy1_r;
    if (ld3) rdy3_r <= rdy2_r;
  end

  // Bias-corrected gauges, captured on acceptance.
  always_ff @(posedge clk) begin
    if (ld0 && meas_acc) begin
      for (int c = 0; c < ftc_pkg::NUM_GAUGES; c++) begin
        diff_r[c] <= ftc_pkg::DIFF_W'(gauge[c]) - ftc_pkg::DIFF_W'(bias_level_r[c]);
      end
    end
  end

  assign lane_ctl.ld_prod = ld1;
  assign lane_ctl.ld_pair = ld2;
  assign lane_ctl.ld_sum  = ld3;

  // One lane per output axis.
  for (genvar r = 0; r < ftc_pkg::NUM_AXES; r++) begin : g_lane
    ftc_lane u_lane (
      .clk  (clk),
      .ctl  (lane_ctl),
      .diff (diff_r),
      .coef (ftc_pkg::COEF[r]),
      .acc  (lane_acc[r])
    );
  end

  ftc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (ld_out),
    .sum_valid  (v3_r),
    .sum_ready  (rdy3_r),
    .acc        (lane_acc),
    .valid      (out_valid),
    .axis       (axis),
    .bias_ready (out_bias_ready)
  );

  assign out_force_x  = axis[0];
  assign out_force_y  = axis[1];
  assign out_force_z  = axis[2];
  assign out_torque_x = axis[3];
  assign out_torque_y = axis[4];
  assign out_torque_z = axis[5];

endmodule

[hw/rtl/ftc_lane.sv]
// One matrix lane: six constant products, a pair-sum level and the final sum.
`timescale 1ns / 1ps

module ftc_lane (
  input  logic                                clk,
  input  ftc_pkg::lane_ctl_t                  ctl,
  input  logic signed [ftc_pkg::DIFF_W-1:0]   diff [ftc_pkg::NUM_GAUGES],
  input  logic signed [ftc_pkg::COEF_W-1:0]   coef [ftc_pkg::NUM_GAUGES],
  output logic signed [ftc_pkg::ACC_W-1:0]    acc
);

  logic signed [ftc_pkg::PROD_W-1:0] prod_r [ftc_pkg::NUM_GAUGES];
  logic signed [ftc_pkg::PAIR_W-1:0] pair_r [ftc_pkg::NUM_GAUGES/2];
  logic signed [ftc_pkg::ACC_W-1:0]  acc_r;

  // Products of the bias-corrected gauges with this row's coefficients.
  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      for (int i = 0; i < ftc_pkg::NUM_GAUGES; i++) begin
        prod_r[i] <= ftc_pkg::PROD_W'(diff[i]) * ftc_pkg::PROD_W'(coef[i]);
      end
    end
  end

  // Pairwise sums of neighboring products.
  always_ff @(posedge clk) begin
    if (ctl.ld_pair) begin
      for (int j = 0; j < ftc_pkg::NUM_GAUGES / 2; j++) begin
        pair_r[j] <= ftc_pkg::PAIR_W'(prod_r[2*j]) + ftc_pkg::PAIR_W'(prod_r[2*j+1]);
      end
    end
  end

  // Row sum in Q.32.
  always_ff @(posedge clk) begin
    if (ctl.ld_sum) begin
      acc_r <= ftc_pkg::ACC_W'(pair_r[0]) + ftc_pkg::ACC_W'(pair_r[1])
             + ftc_pkg::ACC_W'(pair_r[2]);
    end
  end

  assign acc = acc_r;

endmodule

[hw/rtl/ftc_div.sv]
// Constant divider that turns one gauge's bias sum into its floor average.
`timescale 1ns / 1ps

module ftc_div #(
  parameter int BIAS_SAMPLES = ftc_pkg::BIAS_SAMPLES_DEF
) (
  input  logic                                 clk,
  input  ftc_pkg::div_ctl_t                    ctl,
  input  logic signed [ftc_pkg::GAUGE_W+$clog2(BIAS_SAMPLES)-1:0] sum,
  output logic signed [ftc_pkg::GAUGE_W-1:0]   level
);

  localparam int SUM_W = ftc_pkg::GAUGE_W + $clog2(BIAS_SAMPLES);
  // The reciprocal is rounded up and scaled so that the upper product bits
  // give the exact floor quotient for every dividend below 2^SUM_W.
  localparam int SHIFT = SUM_W + $clog2(BIAS_SAMPLES);
  localparam int RCP_W = SUM_W + 1;
  localparam int PRD_W = SHIFT + ftc_pkg::QUO_W;
  localparam longint RCP_VAL = ((64'sd1 <<< SHIFT) + longint'(BIAS_SAMPLES) - 64'sd1)
                               / longint'(BIAS_SAMPLES);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_VAL);
  // Offsetting by N * 2^17 makes the dividend non-negative; the quotient MSB
  // then carries the sign flipped.
  localparam logic [SUM_W-1:0] OFFSET = SUM_W'(BIAS_SAMPLES) << (ftc_pkg::GAUGE_W - 1);

  logic [SUM_W-1:0]            biased;
  logic [PRD_W-1:0]            prod;
  logic [ftc_pkg::QUO_W-1:0]   quo_r;

  assign biased = $unsigned(sum) + OFFSET;
  assign prod   = PRD_W'(biased) * PRD_W'(RCP);

  // Quotient captured in the cycle after the run ends.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      quo_r <= prod[PRD_W-1:SHIFT];
    end
  end

  assign level = {~quo_r[ftc_pkg::QUO_W-1], quo_r[ftc_pkg::QUO_W-2:0]};

endmodule

[hw/rtl/ftc_merge.sv]
// Merging stage: rounds and saturates the lane sums into the output register.
`timescale 1ns / 1ps

module ftc_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  logic                               sum_valid,
  input  logic                               sum_ready,
  input  logic signed [ftc_pkg::ACC_W-1:0]   acc [ftc_pkg::NUM_AXES],
  output logic                               valid,
  output logic signed [ftc_pkg::OUT_W-1:0]   axis [ftc_pkg::NUM_AXES],
  output logic                               bias_ready
);

  logic                              valid_r;
  logic signed [ftc_pkg::OUT_W-1:0]  axis_r [ftc_pkg::NUM_AXES];
  logic signed [ftc_pkg::OUT_W-1:0]  axis_nxt [ftc_pkg::NUM_AXES];
  logic                              bias_ready_r;

  // Round half up to Q15.16, then clamp to the 32-bit range.
  always_comb begin
    logic signed [ftc_pkg::ACC_W-1:0] rnd;
    logic signed [ftc_pkg::SH_W-1:0]  sh;
    for (int a = 0; a < ftc_pkg::NUM_AXES; a++) begin
      rnd = acc[a] + ftc_pkg::ROUND_HALF;
      sh  = rnd[ftc_pkg::ACC_W-1:ftc_pkg::FRAC_DROP];
      if (sh > ftc_pkg::SH_MAX) begin
        axis_nxt[a] = ftc_pkg::OUT_W'(ftc_pkg::SH_MAX);
      end else if (sh < ftc_pkg::SH_MIN) begin
        axis_nxt[a] = ftc_pkg::OUT_W'(ftc_pkg::SH_MIN);
      end else begin
        axis_nxt[a] = sh[ftc_pkg::OUT_W-1:0];
      end
    end
  end

  // Output beat flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= sum_valid;
    end
  end

  // Output beat payload.
  always_ff @(posedge clk) begin
    if (load && sum_valid) begin
      axis_r       <= axis_nxt;
      bias_ready_r <= sum_ready;
    end
  end

  assign valid      = valid_r;
  assign axis       = axis_r;
  assign bias_ready = bias_ready_r;

endmodule

[dv/six_axis_force_torque_converter_tb.sv]
// Self-checking testbench of the six-axis force/torque converter.
`timescale 1ns / 1ps

module six_axis_force_torque_converter_tb;

  localparam int BIAS_RUN     = ftc_pkg::BIAS_SAMPLES_DEF;
  localparam int TOTAL_FRAMES = 900;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLDOFF_LEN  = 300;
  localparam int TAIL_CYCLES  = 40;

  localparam logic signed [ftc_pkg::GAUGE_W-1:0] GAUGE_MAX =
    {1'b0, {(ftc_pkg::GAUGE_W - 1){1'b1}}};
  localparam logic signed [ftc_pkg::GAUGE_W-1:0] GAUGE_MIN =
    {1'b1, {(ftc_pkg::GAUGE_W - 1){1'b0}}};

  // Calibration matrix in millionths; rows 0..2 are forces, rows 3..5 torques.
  localparam longint CAL_MICRO [ftc_pkg::NUM_AXES][ftc_pkg::NUM_GAUGES] = '{
    '{-22, 1325, -35134, 640126, 51951, -641909},
    '{17570, -743414, -16234, 372558, -32329, 366082},
    '{-1184654, -12028, -1165485, -14266, -1174821, 2540},
    '{7847, -144965, 552931, 79813, -571950, 71877},
    '{-661215, -7048, 337836, -125610, 315335, 132327},
    '{-10556, 346443, -9666, 344562, -31572, 339944}
  };

  typedef struct {
    logic                               cmd;
    logic signed [ftc_pkg::GAUGE_W-1:0] gauge [ftc_pkg::NUM_GAUGES];
  } gauge_frame_t;

  typedef struct {
    logic signed [ftc_pkg::OUT_W-1:0] axis [ftc_pkg::NUM_AXES];
    logic                             bias_ready;
  } wrench_t;

  // Tracks the bias state, predicts each wrench and compares it with the block.
  class wrench_checker;
    longint  gain [ftc_pkg::NUM_AXES][ftc_pkg::NUM_GAUGES];
    longint  run_sum [ftc_pkg::NUM_GAUGES];
    longint  offset [ftc_pkg::NUM_GAUGES];
    int      run_len;
    bit      calibrated;
    wrench_t expected_q [$];
    int      errors;
    int      checked;
    string   axis_name [ftc_pkg::NUM_AXES] = '{"force_x", "force_y", "force_z",
                                               "torque_x", "torque_y", "torque_z"};

    function new();
      int a;
      int c;
      for (a = 0; a < ftc_pkg::NUM_AXES; a++) begin
        for (c = 0; c < ftc_pkg::NUM_GAUGES; c++) begin
          gain[a][c] = gain_q20(CAL_MICRO[a][c], a >= 3);
        end
      end
      for (c = 0; c < ftc_pkg::NUM_GAUGES; c++) begin
        run_sum[c] = 0;
        offset[c]  = 0;
      end
      run_len    = 0;
      calibrated = 0;
      errors     = 0;
      checked    = 0;
    endfunction

    // Row scale folded into a Q.20 gain, rounded half away from zero.
    function longint gain_q20(longint micro, bit torque_row);
      longint num;
      longint den;
      longint mag;
      num = micro * (torque_row ? -64'sd123 : -64'sd204) * 64'sd1048576;
      den = torque_row ? 64'sd100000000 : 64'sd10000000;
      mag = ((num < 0 ? -num : num) + den / 2) / den;
      return (num < 0) ? -mag : mag;
    endfunction

    function longint floor_div(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) begin
        q = q - 1;
      end
      return q;
    endfunction

    // Bias beats update the running average; measure beats queue a wrench.
    function void take_frame(gauge_frame_t f);
      wrench_t w;
      longint  acc;
      longint  q;
      int      a;
      int      c;
      if (f.cmd == ftc_pkg::CMD_BIAS) begin
        for (c = 0; c < ftc_pkg::NUM_GAUGES; c++) begin
          if (run_len == 0) begin
            run_sum[c] = 0;
          end
          run_sum[c] += longint'(f.gauge[c]);
        end
        run_len++;
        if (run_len >= BIAS_RUN) begin
          for (c = 0; c < ftc_pkg::NUM_GAUGES; c++) begin
            offset[c] = floor_div(run_sum[c], BIAS_RUN);
          end
          run_len    = 0;
          calibrated = 1;
        end
        return;
      end
      for (a = 0; a < ftc_pkg::NUM_AXES; a++) begin
        acc = 0;
        for (c = 0; c < ftc_pkg::NUM_GAUGES; c++) begin
          acc += (longint'(f.gauge[c]) - offset[c]) * gain[a][c];
        end
        q = (acc + 64'sd32768) >>> 16;
        if (q > 64'sd2147483647) begin
          q = 64'sd2147483647;
        end else if (q < -64'sd2147483648) begin
          q = -64'sd2147483648;
        end
        w.axis[a] = ftc_pkg::OUT_W'(q);
      end
      w.bias_ready = calibrated;
      expected_q.push_back(w);
    endfunction

    function void check_wrench(wrench_t got);
      wrench_t exp_w;
      int      a;
      if (expected_q.size() == 0) begin
        $error("output beat with no measure beat pending");
        errors++;
        return;
      end
      exp_w = expected_q.pop_front();
      checked++;
      for (a = 0; a < ftc_pkg::NUM_AXES; a++) begin
        if (got.axis[a] !== exp_w.axis[a]) begin
          $error("%s: expected %0d, got %0d", axis_name[a], exp_w.axis[a], got.axis[a]);
          errors++;
        end
      end
      if (got.bias_ready !== exp_w.bias_ready) begin
        $error("bias_ready: expected %0d, got %0d", exp_w.bias_ready, got.bias_ready);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  logic                               in_cmd;
  logic signed [ftc_pkg::GAUGE_W-1:0] in_gauge_0;
  logic signed [ftc_pkg::GAUGE_W-1:0] in_gauge_1;
  logic signed [ftc_pkg::GAUGE_W-1:0] in_gauge_2;
  logic signed [ftc_pkg::GAUGE_W-1:0] in_gauge_3;
  logic signed [ftc_pkg::GAUGE_W-1:0] in_gauge_4;
  logic signed [ftc_pkg::GAUGE_W-1:0] in_gauge_5;
  logic                               out_valid;
  logic                               out_stall;
  logic signed [ftc_pkg::OUT_W-1:0]   out_force_x;
  logic signed [ftc_pkg::OUT_W-1:0]   out_force_y;
  logic signed [ftc_pkg::OUT_W-1:0]   out_force_z;
  logic signed [ftc_pkg::OUT_W-1:0]   out_torque_x;
  logic signed [ftc_pkg::OUT_W-1:0]   out_torque_y;
  logic signed [ftc_pkg::OUT_W-1:0]   out_torque_z;
  logic                               out_bias_ready;

  wrench_checker board = new();
  int            frames_sent;
  int            burst_left;
  int            quiet_cycles;

  six_axis_force_torque_converter #(
    .BIAS_SAMPLES(BIAS_RUN)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_gauge_0    (in_gauge_0),
    .in_gauge_1    (in_gauge_1),
    .in_gauge_2    (in_gauge_2),
    .in_gauge_3    (in_gauge_3),
    .in_gauge_4    (in_gauge_4),
    .in_gauge_5    (in_gauge_5),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_force_x   (out_force_x),
    .out_force_y   (out_force_y),
    .out_force_z   (out_force_z),
    .out_torque_x  (out_torque_x),
    .out_torque_y  (out_torque_y),
    .out_torque_z  (out_torque_z),
    .out_bias_ready(out_bias_ready)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gauge values lean on the rails, zero and all ones; the rest are uniform.
  function automatic logic signed [ftc_pkg::GAUGE_W-1:0] rand_gauge();
    case ($urandom_range(0, 9))
      0: begin
        return GAUGE_MAX;
      end
      1: begin
        return GAUGE_MIN;
      end
      2: begin
        return '0;
      end
      3: begin
        return '1;
      end
      default: begin
        return ftc_pkg::GAUGE_W'($urandom);
      end
    endcase
  endfunction

  function automatic gauge_frame_t random_frame(logic cmd);
    gauge_frame_t f;
    int           c;
    f.cmd = cmd;
    for (c = 0; c < ftc_pkg::NUM_GAUGES; c++) begin
      f.gauge[c] = rand_gauge();
    end
    return f;
  endfunction

  // Even channels get one value, odd channels the other.
  function automatic gauge_frame_t split_frame(logic cmd,
                                               logic signed [ftc_pkg::GAUGE_W-1:0] even_v,
                                               logic signed [ftc_pkg::GAUGE_W-1:0] odd_v);
    gauge_frame_t f;
    int           c;
    f.cmd = cmd;
    for (c = 0; c < ftc_pkg::NUM_GAUGES; c++) begin
      f.gauge[c] = (c % 2 == 0) ? even_v : odd_v;
    end
    return f;
  endfunction

  // Present one beat at the falling edge and hold it until the block takes it.
  task automatic send_frame(gauge_frame_t f);
    in_valid   <= 1'b1;
    in_cmd     <= f.cmd;
    in_gauge_0 <= f.gauge[0];
    in_gauge_1 <= f.gauge[1];
    in_gauge_2 <= f.gauge[2];
    in_gauge_3 <= f.gauge[3];
    in_gauge_4 <= f.gauge[4];
    in_gauge_5 <= f.gauge[5];
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    board.take_frame(f);
    frames_sent++;
    @(negedge clk);
  endtask

  // Bursts of random length separated by random gaps, some of them empty.
  task automatic offer_frame(gauge_frame_t f);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_frame(f);
  endtask

  // Drop valid and wait until every predicted wrench has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (board.pending() != 0);
  endtask

  // Stimulus and final verdict.
  initial begin
    gauge_frame_t                       f;
    logic signed [ftc_pkg::GAUGE_W-1:0] center [ftc_pkg::NUM_GAUGES];
    longint                             v;
    int                                 kind;
    int                                 c;
    bit                                 tight;
    bit                                 paused;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_cmd       = ftc_pkg::CMD_MEASURE;
    in_gauge_0   = '0;
    in_gauge_1   = '0;
    in_gauge_2   = '0;
    in_gauge_3   = '0;
    in_gauge_4   = '0;
    in_gauge_5   = '0;
    frames_sent  = 0;
    burst_left   = 0;
    paused       = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Measures before any bias: zero offset and bias_ready low.
    send_frame(split_frame(ftc_pkg::CMD_MEASURE, '0, '0));
    send_frame(split_frame(ftc_pkg::CMD_MEASURE, GAUGE_MAX, GAUGE_MAX));
    send_frame(split_frame(ftc_pkg::CMD_MEASURE, GAUGE_MIN, GAUGE_MIN));
    // A full bias run at the rails, then a measure at the opposite rails so the
    // differences reach both ends of their range, and one with zero difference.
    repeat (BIAS_RUN) send_frame(split_frame(ftc_pkg::CMD_BIAS, GAUGE_MIN, GAUGE_MAX));
    send_frame(split_frame(ftc_pkg::CMD_MEASURE, GAUGE_MAX, GAUGE_MIN));
    send_frame(split_frame(ftc_pkg::CMD_MEASURE, GAUGE_MIN, GAUGE_MAX));
    // A measure in the middle of a partial run keeps the old bias.
    repeat (2) send_frame(random_frame(ftc_pkg::CMD_BIAS));
    send_frame(random_frame(ftc_pkg::CMD_MEASURE));
    send_frame(random_frame(ftc_pkg::CMD_BIAS));
    drain_results();

    // Random traffic: mostly measures, some full bias runs, some lone bias beats.
    while (frames_sent < TOTAL_FRAMES) begin
      if (!paused && frames_sent >= TOTAL_FRAMES / 2) begin
        paused = 1;
        drain_results();
      end
      kind = $urandom_range(0, 99);
      if (kind < 78) begin
        offer_frame(random_frame(ftc_pkg::CMD_MEASURE));
      end else if (kind < 84) begin
        // A tight run sits around one level per gauge, as a real sensor would.
        tight = 1'($urandom_range(0, 1));
        for (c = 0; c < ftc_pkg::NUM_GAUGES; c++) begin
          center[c] = rand_gauge();
        end
        repeat (BIAS_RUN) begin
          f = random_frame(ftc_pkg::CMD_BIAS);
          if (tight) begin
            for (c = 0; c < ftc_pkg::NUM_GAUGES; c++) begin
              v = longint'(center[c]) + int'($urandom_range(0, 255)) - 128;
              if (v > longint'(GAUGE_MAX)) begin
                v = longint'(GAUGE_MAX);
              end else if (v < longint'(GAUGE_MIN)) begin
                v = longint'(GAUGE_MIN);
              end
              f.gauge[c] = ftc_pkg::GAUGE_W'(v);
            end
          end
          offer_frame(f);
        end
      end else begin
        offer_frame(random_frame(ftc_pkg::CMD_BIAS));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Output stall pattern, with one long hold-off that backs the pipeline up.
  initial begin
    int  mode;
    int  span;
    bit  held;
    out_stall = 1'b0;
    held      = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && board.checked >= 120) begin
        held = 1;
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HOLDOFF_LEN) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(0, 9) < 7);
          end
          default: begin
            out_stall <= 1'($urandom_range(0, 1));
          end
        endcase
      end
    end
  end

  // Every accepted output beat is checked against the oldest prediction.
  always @(posedge clk) begin
    wrench_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.axis[0]    = out_force_x;
      got.axis[1]    = out_force_y;
      got.axis[2]    = out_force_z;
      got.axis[3]    = out_torque_x;
      got.axis[4]    = out_torque_y;
      got.axis[5]    = out_torque_z;
      got.bias_ready = out_bias_ready;
      board.check_wrench(got);
    end
  end

  // Ends the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
hw/rtl/ftc_pkg.sv
hw/rtl/ftc_lane.sv
hw/rtl/ftc_div.sv
hw/rtl/ftc_merge.sv
hw/rtl/six_axis_force_torque_converter.sv
dv/six_axis_force_torque_converter_tb.sv
